/* hw/rtl/pps_pkg.sv */
// shared constants and types for the preemptive priority job scheduler
package pps_pkg;

  localparam int unsigned HeapDepth = 64;
  localparam int unsigned TimeW     = 40;
  localparam int unsigned PrioW     = 32;
  localparam int unsigned LenW      = 32;
  localparam int unsigned TagW      = 16;
  localparam int unsigned SeqW      = 16;

  // one heap entry: sequence, tag, remaining length, priority (lowest bits first)
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [LenW-1:0]  rem;
    logic [TagW-1:0]  tag;
    logic [SeqW-1:0]  seq;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  localparam logic OpArrive = 1'b0;
  localparam logic OpFlush  = 1'b1;

  localparam logic StDone   = 1'b0;
  localparam logic StReject = 1'b1;

  // true when entry a is served before entry b
  function automatic logic outranks(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = a.prio > b.prio;
    end else begin
      r = a.seq > b.seq;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/pps_ram.sv */
// generic single-port write, single-port read ram with registered read
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/preemptive_priority_job_scheduler.sv */
// top level of the preemptive priority job scheduler
//
// one server runs jobs highest priority first, later arrival winning ties.
// input stream in_*: in_tuser is the op (0 arrival, 1 flush); in_tdata holds
// arrival_time, job_priority, job_length and job_tag. an arrival first
// advances time to its arrival tick, completing top-of-heap jobs on the way,
// then is inserted into a binary heap kept in one ram with registered read.
// a flush drains the whole heap in priority order.
// output stream out_*: one word per completion or rejection, out_tlast on
// the final word caused by an input; an accepted arrival with no completion
// and a flush of an empty heap produce no word.
// one item at a time, in_tready is high only in idle. an insert climbs with a
// parent read and a compare per level, a completion sinks with a left read, a
// right read and a compare per level, and a partial advance rewrites the root.
// each word is parked in a pending register until the next one is known, so
// out_tlast can be set; the word before it then moves to the output register.
// reset clears count, time, the sequence counter and both word registers;
// the heap ram needs no clearing since only entries below the count are read.
// when the receiver stalls the output word holds and the sequencer waits
// once both the pending and the output register are full.
module preemptive_priority_job_scheduler #(
  parameter int unsigned HEAP_DEPTH = pps_pkg::HeapDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // arrival_time, job_priority, job_length, job_tag
  input  logic         in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // done_tag, finish_time, pad
  output logic         out_tuser, // status
  output logic         out_tlast
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TW = pps_pkg::TimeW;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_TOP    = 13'b0000000000010,  // read heap root, pick next step
    S_ADV    = 13'b0000000000100,  // advance time with root
    S_EMIT   = 13'b0000000001000,  // park completion word
    S_POPRD  = 13'b0000000010000,  // read last entry to move to root
    S_POPLD  = 13'b0000000100000,  // latch moved entry
    S_SINKL  = 13'b0000001000000,  // read left child
    S_SINKR  = 13'b0000010000000,  // read right child
    S_SINKC  = 13'b0000100000000,  // compare and move down
    S_PUSHRD = 13'b0001000000000,  // read parent
    S_PUSHC  = 13'b0010000000000,  // compare and move up
    S_REJ    = 13'b0100000000000,  // park rejection word
    S_FIN    = 13'b1000000000000   // release last word
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]           count_r, count_nxt;
  logic [TW-1:0]           time_r, time_nxt;
  logic [pps_pkg::SeqW-1:0] seq_r, seq_nxt;
  logic                    op_r, op_nxt;
  logic [31:0]             arr_r, arr_nxt;
  logic [31:0]             gap_r, gap_nxt;     // arrival minus time, valid when time is earlier
  pps_pkg::entry_t         new_r, new_nxt;     // job to insert
  pps_pkg::entry_t         sink_r, sink_nxt;   // entry sinking after a pop
  pps_pkg::entry_t         best_r, best_nxt;   // left child during sink
  logic [AW-1:0]           bidx_r, bidx_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [pps_pkg::TagW-1:0] wtag_r, wtag_nxt;  // tag of the job just completed

  // pending word, waits until it is known whether it is the last
  logic                    pv_r, pv_nxt;
  logic [pps_pkg::TagW-1:0] ptag_r, ptag_nxt;
  logic [TW-1:0]           ptime_r, ptime_nxt;
  logic                    pst_r, pst_nxt;

  // output word
  logic                    ov_r, ov_nxt;
  logic [pps_pkg::TagW-1:0] otag_r, otag_nxt;
  logic [TW-1:0]           otime_r, otime_nxt;
  logic                    ost_r, ost_nxt;
  logic                    olast_r, olast_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  pps_pkg::entry_t wdata, rdata;

  pps_ram #(.WIDTH(pps_pkg::EntryW), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [TW-1:0]            arr_ext;
  logic [CW:0]              lchild, rchild;
  logic [AW-1:0]            parent;
  logic                     out_free;
  logic                     stage_ok;
  logic                     stage_req;
  logic [pps_pkg::TagW-1:0] stage_tag;
  logic [TW-1:0]            stage_time;
  logic                     stage_st;
  pps_pkg::entry_t          cand;
  logic [AW-1:0]            cand_idx;

  assign arr_ext  = {{(TW-32){1'b0}}, arr_r};
  assign lchild   = (CW+1)'({idx_r, 1'b1});
  assign rchild   = lchild + (CW+1)'(1);
  assign parent   = AW'((idx_r - 1'b1) >> 1);
  assign out_free = !ov_r || out_tready;
  assign stage_ok = !pv_r || out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {8'd0, otime_r, otag_r};
  assign out_tuser  = ost_r;
  assign out_tlast  = olast_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    time_nxt   = time_r;
    seq_nxt    = seq_r;
    op_nxt     = op_r;
    arr_nxt    = arr_r;
    gap_nxt    = gap_r;
    new_nxt    = new_r;
    sink_nxt   = sink_r;
    best_nxt   = best_r;
    bidx_nxt   = bidx_r;
    idx_nxt    = idx_r;
    wtag_nxt   = wtag_r;
    pv_nxt     = pv_r;
    ptag_nxt   = ptag_r;
    ptime_nxt  = ptime_r;
    pst_nxt    = pst_r;
    ov_nxt     = ov_r;
    otag_nxt   = otag_r;
    otime_nxt  = otime_r;
    ost_nxt    = ost_r;
    olast_nxt  = olast_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = new_r;
    raddr      = '0;
    stage_req  = 1'b0;
    stage_tag  = wtag_r;
    stage_time = time_r;
    stage_st   = pps_pkg::StDone;
    cand       = best_r;
    cand_idx   = bidx_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          arr_nxt      = in_tdata[31:0];
          new_nxt.prio = in_tdata[63:32];
          new_nxt.rem  = in_tdata[95:64];
          new_nxt.tag  = in_tdata[111:96];
          new_nxt.seq  = seq_r;
          state_nxt    = S_TOP;
        end
      end
      S_TOP: begin
        raddr   = '0;
        gap_nxt = arr_r - time_r[31:0];
        if (count_r != '0 && (op_r == pps_pkg::OpFlush || time_r < arr_ext)) begin
          state_nxt = S_ADV;
        end else if (op_r == pps_pkg::OpFlush) begin
          state_nxt = S_FIN;
        end else begin
          // empty heap or arrival reached: time jumps, never goes back
          if (time_r < arr_ext) begin
            time_nxt = arr_ext;
          end
          if (count_r >= CW'(HEAP_DEPTH)) begin
            state_nxt = S_REJ;
          end else begin
            idx_nxt   = AW'(count_r);
            count_nxt = count_r + 1'b1;
            seq_nxt   = seq_r + 1'b1;
            state_nxt = S_PUSHRD;
          end
        end
      end
      S_ADV: begin
        wtag_nxt = rdata.tag;
        if (op_r == pps_pkg::OpFlush || rdata.rem <= gap_r) begin
          // root finishes, time wraps at 40 bits
          time_nxt  = time_r + {{(TW-pps_pkg::LenW){1'b0}}, rdata.rem};
          count_nxt = count_r - 1'b1;
          state_nxt = S_EMIT;
        end else begin
          // root partly served up to the arrival tick
          we        = 1'b1;
          waddr     = '0;
          wdata     = rdata;
          wdata.rem = rdata.rem - gap_r;
          time_nxt  = arr_ext;
          state_nxt = S_TOP;
        end
      end
      S_EMIT: begin
        stage_req = 1'b1;
        if (stage_ok) begin
          state_nxt = S_POPRD;
        end
      end
      S_POPRD: begin
        raddr     = AW'(count_r);
        state_nxt = (count_r == '0) ? S_TOP : S_POPLD;
      end
      S_POPLD: begin
        sink_nxt  = rdata;
        idx_nxt   = '0;
        state_nxt = S_SINKL;
      end
      S_SINKL: begin
        if (lchild < {1'b0, count_r}) begin
          raddr     = AW'(lchild);
          state_nxt = S_SINKR;
        end else begin
          we        = 1'b1;
          waddr     = idx_r;
          wdata     = sink_r;
          state_nxt = S_TOP;
        end
      end
      S_SINKR: begin
        best_nxt = rdata;
        bidx_nxt = AW'(lchild);
        if (rchild < {1'b0, count_r}) begin
          raddr = AW'(rchild);
        end
        state_nxt = S_SINKC;
      end
      S_SINKC: begin
        if (rchild < {1'b0, count_r} && pps_pkg::outranks(rdata, best_r)) begin
          cand     = rdata;
          cand_idx = AW'(rchild);
        end
        we    = 1'b1;
        waddr = idx_r;
        if (pps_pkg::outranks(cand, sink_r)) begin
          wdata     = cand;
          idx_nxt   = cand_idx;
          state_nxt = S_SINKL;
        end else begin
          wdata     = sink_r;
          state_nxt = S_TOP;
        end
      end
      S_PUSHRD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = new_r;
          state_nxt = S_FIN;
        end else begin
          raddr     = parent;
          state_nxt = S_PUSHC;
        end
      end
      S_PUSHC: begin
        we    = 1'b1;
        waddr = idx_r;
        if (pps_pkg::outranks(new_r, rdata)) begin
          wdata     = rdata;
          idx_nxt   = parent;
          state_nxt = S_PUSHRD;
        end else begin
          wdata     = new_r;
          state_nxt = S_FIN;
        end
      end
      S_REJ: begin
        stage_req  = 1'b1;
        stage_tag  = new_r.tag;
        stage_time = '0;
        stage_st   = pps_pkg::StReject;
        if (stage_ok) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // the pending word is the last one of this item
        if (!pv_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          otag_nxt  = ptag_r;
          otime_nxt = ptime_r;
          ost_nxt   = pst_r;
          olast_nxt = 1'b1;
          pv_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a new word pushes the pending one out, not last
    if (stage_req && stage_ok) begin
      if (pv_r) begin
        ov_nxt    = 1'b1;
        otag_nxt  = ptag_r;
        otime_nxt = ptime_r;
        ost_nxt   = pst_r;
        olast_nxt = 1'b0;
      end
      pv_nxt    = 1'b1;
      ptag_nxt  = stage_tag;
      ptime_nxt = stage_time;
      pst_nxt   = stage_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      time_r  <= '0;
      seq_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      time_r  <= time_nxt;
      seq_r   <= seq_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    arr_r   <= arr_nxt;
    gap_r   <= gap_nxt;
    new_r   <= new_nxt;
    sink_r  <= sink_nxt;
    best_r  <= best_nxt;
    bidx_r  <= bidx_nxt;
    idx_r   <= idx_nxt;
    wtag_r  <= wtag_nxt;
    ptag_r  <= ptag_nxt;
    ptime_r <= ptime_nxt;
    pst_r   <= pst_nxt;
    otag_r  <= otag_nxt;
    otime_r <= otime_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  // a held word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped");

  // a held word keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) &&
    $stable(out_tlast))
    else $error("output word changed while held");

  // heap never exceeds its depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH))
    else $error("heap count overflow");

  // no input taken while an item is in work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("input accepted while busy");

endmodule
